// ===== rtl/core/ltc_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Luma tone curve package
// Shared configuration type and the fixed color conversion coefficients.
// -----------------------------------------------------------------------------
package ltc_pkg;

    localparam int THRESHOLD_BITS = 8;
    localparam int SLOPE_BITS     = 12;
    localparam int COEF_BITS      = 16;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [THRESHOLD_BITS-1:0] threshold_0;
        logic [THRESHOLD_BITS-1:0] threshold_1;
        logic [THRESHOLD_BITS-1:0] threshold_2;
        logic [THRESHOLD_BITS-1:0] threshold_3;
        logic [SLOPE_BITS-1:0]     slope_1;
        logic [SLOPE_BITS-1:0]     slope_2;
        logic [SLOPE_BITS-1:0]     slope_3;
    } ltc_cfg_t;

    // Register indexes on the APB port. The last index has no register behind it.
    typedef enum logic [2:0] {
        REG_THRESHOLD_0,
        REG_THRESHOLD_1,
        REG_THRESHOLD_2,
        REG_THRESHOLD_3,
        REG_SLOPE_1,
        REG_SLOPE_2,
        REG_SLOPE_3,
        REG_UNMAPPED
    } reg_idx_t;

    // RGB to luma and chroma, signed Q2.14.
    localparam logic signed [COEF_BITS-1:0] K_YR = 16'sd4889;
    localparam logic signed [COEF_BITS-1:0] K_YG = 16'sd9626;
    localparam logic signed [COEF_BITS-1:0] K_YB = 16'sd1871;
    localparam logic signed [COEF_BITS-1:0] K_UR = -16'sd2769;
    localparam logic signed [COEF_BITS-1:0] K_UG = -16'sd5453;
    localparam logic signed [COEF_BITS-1:0] K_UB = 16'sd8223;
    localparam logic signed [COEF_BITS-1:0] K_VR = 16'sd8212;
    localparam logic signed [COEF_BITS-1:0] K_VG = -16'sd6875;
    localparam logic signed [COEF_BITS-1:0] K_VB = -16'sd1335;

    // Luma and chroma back to RGB, signed Q2.14.
    localparam logic signed [COEF_BITS-1:0] K_RV = 16'sd22938;
    localparam logic signed [COEF_BITS-1:0] K_GU = -16'sd5620;
    localparam logic signed [COEF_BITS-1:0] K_GV = -16'sd11649;
    localparam logic signed [COEF_BITS-1:0] K_BU = 16'sd28918;

endpackage
`default_nettype wire

// ===== rtl/core/luma_tone_curve_pixel_core.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Luma tone curve pixel core
// Takes one RGBA pixel per clock while the pipeline has room and returns it
// with its luma reshaped by a five-segment piecewise-linear curve set through
// the APB registers. The datapath is five register stages deep: color
// conversion, segment products, curve sum, inverse chroma products and the
// final sum with saturation. Each stage has its own valid bit and fills its
// bubbles while the output stalls; in_ready falls only once all five stages
// hold pixels and the output is not taken. Alpha travels with the pixel
// unchanged.
// -----------------------------------------------------------------------------
module luma_tone_curve_pixel_core
    import ltc_pkg::*;
#(
    parameter int PIXEL_BITS = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [4:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [PIXEL_BITS-1:0] red_in,
    input  wire logic [PIXEL_BITS-1:0] green_in,
    input  wire logic [PIXEL_BITS-1:0] blue_in,
    input  wire logic [PIXEL_BITS-1:0] alpha_in,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [PIXEL_BITS-1:0] red_out,
    output logic      [PIXEL_BITS-1:0] green_out,
    output logic      [PIXEL_BITS-1:0] blue_out,
    output logic      [PIXEL_BITS-1:0] alpha_out
);

    ltc_cfg_t cfg;

    logic                          ycc_valid, ycc_ready;
    logic        [PIXEL_BITS+7:0]  y_q8;
    logic signed [PIXEL_BITS+8:0]  cb_q8, cr_q8;
    logic        [PIXEL_BITS-1:0]  ycc_alpha;

    logic                          crv_valid, crv_ready;
    logic        [PIXEL_BITS+14:0] yc_q8;
    logic signed [PIXEL_BITS+8:0]  crv_cb_q8, crv_cr_q8;
    logic        [PIXEL_BITS-1:0]  crv_alpha;

    ltc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ltc_rgb2ycc #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_rgb2ycc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .alpha_in  (alpha_in),
        .ycc_valid (ycc_valid),
        .ycc_ready (ycc_ready),
        .y_q8      (y_q8),
        .cb_q8     (cb_q8),
        .cr_q8     (cr_q8),
        .alpha     (ycc_alpha)
    );

    ltc_curve #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_curve (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ycc_valid (ycc_valid),
        .ycc_ready (ycc_ready),
        .y_q8      (y_q8),
        .cb_q8     (cb_q8),
        .cr_q8     (cr_q8),
        .alpha     (ycc_alpha),
        .crv_valid (crv_valid),
        .crv_ready (crv_ready),
        .yc_q8     (yc_q8),
        .crv_cb_q8 (crv_cb_q8),
        .crv_cr_q8 (crv_cr_q8),
        .crv_alpha (crv_alpha)
    );

    ltc_ycc2rgb #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_ycc2rgb (
        .clk       (clk),
        .rst_n     (rst_n),
        .crv_valid (crv_valid),
        .crv_ready (crv_ready),
        .yc_q8     (yc_q8),
        .cb_q8     (crv_cb_q8),
        .cr_q8     (crv_cr_q8),
        .alpha     (crv_alpha),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out)
    );

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready && ycc_valid && crv_valid))
        else $error("input stalled while the pipeline still has room");
    a_curve_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        (crv_valid && !crv_ready) |-> (out_valid && !out_ready))
        else $error("curve stage stalled without an output stall");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ltc_regs.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Luma tone curve configuration registers
// APB-style register file holding the four thresholds and three slopes.
// -----------------------------------------------------------------------------
module ltc_regs
    import ltc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output ltc_cfg_t         cfg
);

    ltc_cfg_t cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_0 <= 8'd51;
            cfg_reg.threshold_1 <= 8'd128;
            cfg_reg.threshold_2 <= 8'd153;
            cfg_reg.threshold_3 <= 8'd204;
            cfg_reg.slope_1     <= 12'd256;
            cfg_reg.slope_2     <= 12'd256;
            cfg_reg.slope_3     <= 12'd256;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_THRESHOLD_0: cfg_reg.threshold_0 <= pwdata[THRESHOLD_BITS-1:0];
                REG_THRESHOLD_1: cfg_reg.threshold_1 <= pwdata[THRESHOLD_BITS-1:0];
                REG_THRESHOLD_2: cfg_reg.threshold_2 <= pwdata[THRESHOLD_BITS-1:0];
                REG_THRESHOLD_3: cfg_reg.threshold_3 <= pwdata[THRESHOLD_BITS-1:0];
                REG_SLOPE_1:     cfg_reg.slope_1     <= pwdata[SLOPE_BITS-1:0];
                REG_SLOPE_2:     cfg_reg.slope_2     <= pwdata[SLOPE_BITS-1:0];
                REG_SLOPE_3:     cfg_reg.slope_3     <= pwdata[SLOPE_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_THRESHOLD_0: prdata = 32'(cfg_reg.threshold_0);
            REG_THRESHOLD_1: prdata = 32'(cfg_reg.threshold_1);
            REG_THRESHOLD_2: prdata = 32'(cfg_reg.threshold_2);
            REG_THRESHOLD_3: prdata = 32'(cfg_reg.threshold_3);
            REG_SLOPE_1:     prdata = 32'(cfg_reg.slope_1);
            REG_SLOPE_2:     prdata = 32'(cfg_reg.slope_2);
            REG_SLOPE_3:     prdata = 32'(cfg_reg.slope_3);
            default:         prdata = '0;
        endcase
    end

`ifndef ASSERT_OFF
    a_threshold_0_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && idx == REG_THRESHOLD_0) |=> (cfg_reg.threshold_0 == $past(pwdata[7:0])))
        else $error("threshold_0 did not take the written value");
    a_slope_3_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && idx == REG_SLOPE_3) |=> (cfg_reg.slope_3 == $past(pwdata[11:0])))
        else $error("slope_3 did not take the written value");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ltc_rgb2ycc.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Luma tone curve color conversion, forward
// One pipeline stage converting RGB to luma and chroma with 8 fraction bits.
// -----------------------------------------------------------------------------
module ltc_rgb2ycc
    import ltc_pkg::*;
#(
    parameter int PIXEL_BITS = 8
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [PIXEL_BITS-1:0]        red_in,
    input  wire logic [PIXEL_BITS-1:0]        green_in,
    input  wire logic [PIXEL_BITS-1:0]        blue_in,
    input  wire logic [PIXEL_BITS-1:0]        alpha_in,
    output logic                              ycc_valid,
    input  wire logic                         ycc_ready,
    output logic        [PIXEL_BITS+7:0]      y_q8,
    output logic signed [PIXEL_BITS+8:0]      cb_q8,
    output logic signed [PIXEL_BITS+8:0]      cr_q8,
    output logic        [PIXEL_BITS-1:0]      alpha
);

    localparam int SW = PIXEL_BITS + 17;
    localparam int YW = PIXEL_BITS + 8;
    localparam int CW = PIXEL_BITS + 9;
    localparam logic signed [SW-1:0] RND6 = SW'(32);

    logic signed [SW-1:0] r_s, g_s, b_s;
    logic signed [SW-1:0] y_sum, cb_sum, cr_sum;
    logic        [YW-1:0] y_next;
    logic signed [CW-1:0] cb_next, cr_next;

    logic                 valid_reg;
    logic        [YW-1:0] y_reg;
    logic signed [CW-1:0] cb_reg, cr_reg;
    logic [PIXEL_BITS-1:0] alpha_reg;

    assign r_s = SW'($signed({1'b0, red_in}));
    assign g_s = SW'($signed({1'b0, green_in}));
    assign b_s = SW'($signed({1'b0, blue_in}));

    assign y_sum  = SW'(K_YR) * r_s + SW'(K_YG) * g_s + SW'(K_YB) * b_s + RND6;
    assign cb_sum = SW'(K_UR) * r_s + SW'(K_UG) * g_s + SW'(K_UB) * b_s + RND6;
    assign cr_sum = SW'(K_VR) * r_s + SW'(K_VG) * g_s + SW'(K_VB) * b_s + RND6;

    // The arithmetic shift floors, so adding half first rounds half up.
    assign y_next  = YW'(y_sum >>> 6);
    assign cb_next = CW'(cb_sum >>> 6);
    assign cr_next = CW'(cr_sum >>> 6);

    assign in_ready = !valid_reg || ycc_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            y_reg     <= y_next;
            cb_reg    <= cb_next;
            cr_reg    <= cr_next;
            alpha_reg <= alpha_in;
        end
    end

    assign ycc_valid = valid_reg;
    assign y_q8      = y_reg;
    assign cb_q8     = cb_reg;
    assign cr_q8     = cr_reg;
    assign alpha     = alpha_reg;

endmodule
`default_nettype wire

// ===== rtl/core/ltc_curve.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Luma tone curve
// Two pipeline stages: segment lengths times slopes, then the rounded sum.
// -----------------------------------------------------------------------------
module ltc_curve
    import ltc_pkg::*;
#(
    parameter int PIXEL_BITS = 8
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ltc_cfg_t                     cfg,
    input  wire logic                         ycc_valid,
    output logic                              ycc_ready,
    input  wire logic        [PIXEL_BITS+7:0] y_q8,
    input  wire logic signed [PIXEL_BITS+8:0] cb_q8,
    input  wire logic signed [PIXEL_BITS+8:0] cr_q8,
    input  wire logic        [PIXEL_BITS-1:0] alpha,
    output logic                              crv_valid,
    input  wire logic                         crv_ready,
    output logic        [PIXEL_BITS+14:0]     yc_q8,
    output logic signed [PIXEL_BITS+8:0]      crv_cb_q8,
    output logic signed [PIXEL_BITS+8:0]      crv_cr_q8,
    output logic        [PIXEL_BITS-1:0]      crv_alpha
);

    localparam int YW  = PIXEL_BITS + 8;
    localparam int CW  = PIXEL_BITS + 9;
    localparam int PW  = PIXEL_BITS + 20;
    localparam int MW  = PIXEL_BITS + 22;
    localparam int YCW = PIXEL_BITS + 15;

    function automatic logic [YW-1:0] seg_len(
        input logic [YW-1:0] v,
        input logic [YW-1:0] lo,
        input logic [YW-1:0] hi
    );
        logic [YW-1:0] c;
        begin
            c = (v < lo) ? lo : ((v > hi) ? hi : v);
            // A segment whose ends are out of order adds nothing.
            return (lo > hi) ? '0 : YW'(c - lo);
        end
    endfunction

    logic [YW-1:0] t0, t1, t2, t3;
    logic [YW-1:0] l0_next, l4_next;
    logic [PW-1:0] p1_next, p2_next, p3_next;

    logic                 a_valid_reg;
    logic [YW-1:0]        l0_reg, l4_reg;
    logic [PW-1:0]        p1_reg, p2_reg, p3_reg;
    logic signed [CW-1:0] a_cb_reg, a_cr_reg;
    logic [PIXEL_BITS-1:0] a_alpha_reg;
    logic                 a_ready;

    logic [MW-1:0]        mid;
    logic [YCW-1:0]       yc_next;

    logic                 b_valid_reg;
    logic [YCW-1:0]       yc_reg;
    logic signed [CW-1:0] b_cb_reg, b_cr_reg;
    logic [PIXEL_BITS-1:0] b_alpha_reg;
    logic                 b_ready;

    assign t0 = {cfg.threshold_0, PIXEL_BITS'(0)};
    assign t1 = {cfg.threshold_1, PIXEL_BITS'(0)};
    assign t2 = {cfg.threshold_2, PIXEL_BITS'(0)};
    assign t3 = {cfg.threshold_3, PIXEL_BITS'(0)};

    assign l0_next = (y_q8 < t0) ? y_q8 : t0;
    assign l4_next = (y_q8 > t3) ? YW'(y_q8 - t3) : '0;
    assign p1_next = PW'(seg_len(y_q8, t0, t1)) * PW'(cfg.slope_1);
    assign p2_next = PW'(seg_len(y_q8, t1, t2)) * PW'(cfg.slope_2);
    assign p3_next = PW'(seg_len(y_q8, t2, t3)) * PW'(cfg.slope_3);

    assign b_ready   = !b_valid_reg || crv_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign ycc_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= ycc_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ycc_valid && a_ready)
        begin
            l0_reg      <= l0_next;
            l4_reg      <= l4_next;
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            p3_reg      <= p3_next;
            a_cb_reg    <= cb_q8;
            a_cr_reg    <= cr_q8;
            a_alpha_reg <= alpha;
        end
    end

    // The three scaled segments are rounded once, back to 8 fraction bits.
    assign mid     = MW'(p1_reg) + MW'(p2_reg) + MW'(p3_reg) + MW'(128);
    assign yc_next = YCW'(l0_reg) + YCW'(mid >> 8) + YCW'(l4_reg);

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_ready)
        begin
            yc_reg      <= yc_next;
            b_cb_reg    <= a_cb_reg;
            b_cr_reg    <= a_cr_reg;
            b_alpha_reg <= a_alpha_reg;
        end
    end

    assign crv_valid = b_valid_reg;
    assign yc_q8     = yc_reg;
    assign crv_cb_q8 = b_cb_reg;
    assign crv_cr_q8 = b_cr_reg;
    assign crv_alpha = b_alpha_reg;

`ifndef ASSERT_OFF
    a_identity_bound: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (l0_reg <= t0))
        else $error("identity part of the curve exceeds threshold_0");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ltc_ycc2rgb.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Luma tone curve color conversion, inverse
// Two pipeline stages: chroma products, then sum, rounding and saturation.
// -----------------------------------------------------------------------------
module ltc_ycc2rgb
    import ltc_pkg::*;
#(
    parameter int PIXEL_BITS = 8
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         crv_valid,
    output logic                              crv_ready,
    input  wire logic        [PIXEL_BITS+14:0] yc_q8,
    input  wire logic signed [PIXEL_BITS+8:0] cb_q8,
    input  wire logic signed [PIXEL_BITS+8:0] cr_q8,
    input  wire logic        [PIXEL_BITS-1:0] alpha,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic        [PIXEL_BITS-1:0]      red_out,
    output logic        [PIXEL_BITS-1:0]      green_out,
    output logic        [PIXEL_BITS-1:0]      blue_out,
    output logic        [PIXEL_BITS-1:0]      alpha_out
);

    localparam int YCW = PIXEL_BITS + 15;
    localparam int PW  = PIXEL_BITS + 26;
    localparam int OW  = PIXEL_BITS + 32;
    localparam logic signed [OW-1:0] RND22  = OW'(1 << 21);
    localparam logic signed [OW-1:0] CH_MAX = OW'((1 << PIXEL_BITS) - 1);

    function automatic logic [PIXEL_BITS-1:0] sat_ch(input logic signed [OW-1:0] v);
        begin
            if (v < 0)
            begin
                return '0;
            end
            else if (v > CH_MAX)
            begin
                return PIXEL_BITS'(CH_MAX);
            end
            return PIXEL_BITS'(v);
        end
    endfunction

    logic                  c_valid_reg;
    logic [YCW-1:0]        yc_reg;
    logic signed [PW-1:0]  rv_reg, gu_reg, gv_reg, bu_reg;
    logic [PIXEL_BITS-1:0] c_alpha_reg;
    logic                  c_ready;

    logic signed [OW-1:0]  yq;
    logic signed [OW-1:0]  r_sum, g_sum, b_sum;

    logic                  d_valid_reg;
    logic [PIXEL_BITS-1:0] red_reg, green_reg, blue_reg, d_alpha_reg;
    logic                  d_ready;

    assign d_ready   = !d_valid_reg || out_ready;
    assign c_ready   = !c_valid_reg || d_ready;
    assign crv_ready = c_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
            begin
                c_valid_reg <= crv_valid;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (crv_valid && c_ready)
        begin
            yc_reg      <= yc_q8;
            rv_reg      <= PW'(K_RV) * PW'(cr_q8);
            gu_reg      <= PW'(K_GU) * PW'(cb_q8);
            gv_reg      <= PW'(K_GV) * PW'(cr_q8);
            bu_reg      <= PW'(K_BU) * PW'(cb_q8);
            c_alpha_reg <= alpha;
        end
    end

    // Luma moves from 8 to 22 fraction bits to line up with the products.
    assign yq    = OW'($signed({1'b0, yc_reg})) <<< 14;
    assign r_sum = yq + OW'(rv_reg) + RND22;
    assign g_sum = yq + OW'(gu_reg) + OW'(gv_reg) + RND22;
    assign b_sum = yq + OW'(bu_reg) + RND22;

    always_ff @(posedge clk)
    begin
        if (c_valid_reg && d_ready)
        begin
            red_reg     <= sat_ch(r_sum >>> 22);
            green_reg   <= sat_ch(g_sum >>> 22);
            blue_reg    <= sat_ch(b_sum >>> 22);
            d_alpha_reg <= c_alpha_reg;
        end
    end

    assign out_valid = d_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign alpha_out = d_alpha_reg;

endmodule
`default_nettype wire
